// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the sparse link store.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SLAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define SLAS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/slas_pkg.sv -----
// Types and constants for the sparse link store.
// No dependencies; used by every module of the block.
`default_nettype none

package slas_pkg;

    localparam int SRC_W  = 20;
    localparam int TGT_W  = 10;
    localparam int WGT_W  = 40;
    localparam int RIDX_W = 12;
    localparam int NUM_W  = 12;
    localparam int TOT_W  = 13;
    localparam int STAT_W = 3;
    localparam int IN_W   = 168;
    localparam int OUT_W  = 184;

    typedef logic signed [WGT_W-1:0] wgt_t;

    typedef logic [1:0] wcnt_t;
    localparam wcnt_t WCNT_THREE = 2'd3;

    typedef enum logic [STAT_W-1:0] {
        ST_NEW    = 3'd0,
        ST_ACCUM  = 3'd1,
        ST_ZERO   = 3'd2,
        ST_NOROOM = 3'd3,
        ST_READ   = 3'd4,
        ST_UNUSED = 3'd5
    } status_t;

    typedef enum logic {
        REQ_STORE = 1'b0,
        REQ_READ  = 1'b1
    } req_t;

    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [TGT_W-1:0] tgt;
        wgt_t [2:0]       w;
    } link_ent_t;

endpackage

`default_nettype wire

// ----- hdl/slas_sat_adder.sv -----
// Saturating adder for 40-bit signed Q7.32 weights, shared by all three sums.
// Depends on slas_pkg for the weight type.
`default_nettype none

module slas_sat_adder
    import slas_pkg::*;
(
    input  wire wgt_t a,
    input  wire wgt_t b,
    output wgt_t      sum
);

    logic [WGT_W:0] full;

    assign full = {a[WGT_W-1], a} + {b[WGT_W-1], b};

    // The two top bits differ only when the true sum left the 40-bit range.
    always_comb
    begin
        if (full[WGT_W] == full[WGT_W-1])
        begin
            sum = full[WGT_W-1:0];
        end
        else if (full[WGT_W])
        begin
            sum = {1'b1, {(WGT_W-1){1'b0}}};
        end
        else
        begin
            sum = {1'b0, {(WGT_W-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sparse_link_accumulate_store_top.sv -----
// Top level of the sparse link store: sequencer, slot and link memories.
// Depends on slas_pkg, slas_sat_adder and assert_macros.svh.
//
//  channel   dir  fields
//  s_*       in   tuser: req_type; tdata: src, tgt, weights, read index
//  m_*       out  tdata: status, link number, src, tgt, sums, links total
//  cfg_*     in   weight_count, written when cfg_we is high
//
// After reset a clearing pass empties all TGT_CELLS*MAX_LAYERS slots of the
// slot memory (8192 by default); no beat is taken meanwhile.
// A read passes S_LINK_RD and S_LINK_CHK. A store scans up to MAX_LAYERS
// slots, each via S_SLOT_RD and S_SLOT_CHK and, if used, S_LINK_RD and
// S_LINK_CHK, then S_ACC on a match and S_STORE; memory reads are registered.
// One result register lets a new beat be taken while a result waits.
`default_nettype none
`include "assert_macros.svh"

module sparse_link_accumulate_store_top
    import slas_pkg::*;
#(
    parameter int MAX_LINKS     = 4096,
    parameter int TGT_CELLS     = 1024,
    parameter int MAX_LAYERS    = 8,
    parameter int SRC_ADDR_BITS = 20
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_tvalid,
    output logic             s_tready,
    // src_addr[19:0], tgt_addr[29:20], weight_first[69:30], weight_second[109:70],
    // weight_third[149:110], read_index[161:150]
    input  wire [IN_W-1:0]   s_tdata,
    // req_type[0]
    input  wire [0:0]        s_tuser,
    output logic             m_tvalid,
    input  wire              m_tready,
    // status[2:0], link_number[14:3], link_src[34:15], link_tgt[44:35],
    // sum_first[84:45], sum_second[124:85], sum_third[164:125], links_total[177:165]
    output logic [OUT_W-1:0] m_tdata,
    input  wire              cfg_we,
    input  wire [1:0]        cfg_wdata
);

    localparam int LNK_AW   = $clog2(MAX_LINKS);
    localparam int CNT_W    = $clog2(MAX_LINKS + 1);
    localparam int SLOT_CNT = TGT_CELLS * MAX_LAYERS;
    localparam int SLOT_AW  = $clog2(SLOT_CNT);
    localparam int LAY_W    = $clog2(MAX_LAYERS + 1);
    localparam logic [SRC_W-1:0] SRC_MASK = SRC_W'((64'd1 << SRC_ADDR_BITS) - 64'd1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SLOT_RD  = 8'b0000_0010,
        S_SLOT_CHK = 8'b0000_0100,
        S_LINK_RD  = 8'b0000_1000,
        S_LINK_CHK = 8'b0001_0000,
        S_ACC      = 8'b0010_0000,
        S_STORE    = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    // Memories.
    logic [LNK_AW:0] slot_mem [SLOT_CNT];
    link_ent_t       link_mem [MAX_LINKS];

    state_t             state_reg, state_next;
    logic               clear_reg, clear_next;
    logic [SLOT_AW-1:0] clr_cnt_reg, clr_cnt_next;
    wcnt_t              wcnt_reg;
    logic               is_read_reg, is_read_next;
    logic               three_reg, three_next;
    logic               new_reg, new_next;
    logic [SRC_W-1:0]   src_reg, src_next;
    logic [TGT_W-1:0]   tgt_reg, tgt_next;
    wgt_t [2:0]         w_reg, w_next;
    logic [LAY_W-1:0]   layer_reg, layer_next;
    logic [LNK_AW-1:0]  link_raddr_reg, link_raddr_next;
    logic [LNK_AW:0]    slot_rd_reg;
    link_ent_t          link_rd_reg;
    logic [1:0]         acc_idx_reg, acc_idx_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    status_t            res_status_reg, res_status_next;
    logic [LNK_AW-1:0]  res_num_reg, res_num_next;
    link_ent_t          res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    logic               slot_we;
    logic [SLOT_AW-1:0] slot_addr;
    logic [SLOT_AW-1:0] slot_waddr;
    logic [LNK_AW:0]    slot_wdata;
    logic               link_we;
    wgt_t               add_sum;
    logic               accept;
    wgt_t [2:0]         w_in;
    logic [TGT_W-1:0]   tgt_in;
    logic [RIDX_W-1:0]  ridx_in;
    logic               zero_in;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !clear_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign tgt_in  = s_tdata[29:20];
    assign ridx_in = s_tdata[161:150];
    assign w_in[0] = s_tdata[69:30];
    assign w_in[1] = (wcnt_reg == WCNT_THREE) ? wgt_t'(s_tdata[109:70]) : '0;
    assign w_in[2] = (wcnt_reg == WCNT_THREE) ? wgt_t'(s_tdata[149:110]) : '0;
    assign zero_in = (w_in[0] == '0) && (w_in[1] == '0) && (w_in[2] == '0);

    assign slot_addr = SLOT_AW'(32'(tgt_reg) * 32'(MAX_LAYERS) + 32'(layer_reg));

    slas_sat_adder u_adder
    (
        .a   (res_reg.w[acc_idx_reg]),
        .b   (w_reg[acc_idx_reg]),
        .sum (add_sum)
    );

    always_comb
    begin
        state_next      = state_reg;
        clear_next      = clear_reg;
        clr_cnt_next    = clr_cnt_reg;
        is_read_next    = is_read_reg;
        three_next      = three_reg;
        new_next        = new_reg;
        src_next        = src_reg;
        tgt_next        = tgt_reg;
        w_next          = w_reg;
        layer_next      = layer_reg;
        link_raddr_next = link_raddr_reg;
        acc_idx_next    = acc_idx_reg;
        total_next      = total_reg;
        res_status_next = res_status_reg;
        res_num_next    = res_num_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        slot_we         = 1'b0;
        slot_waddr      = slot_addr;
        slot_wdata      = {1'b1, total_reg[LNK_AW-1:0]};
        link_we         = 1'b0;

        if (clear_reg)
        begin
            slot_we    = 1'b1;
            slot_waddr = clr_cnt_reg;
            slot_wdata = '0;
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == SLOT_AW'(SLOT_CNT - 1))
            begin
                clear_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    is_read_next = (s_tuser[0] == REQ_READ);
                    three_next   = (wcnt_reg == WCNT_THREE);
                    src_next     = s_tdata[19:0] & SRC_MASK;
                    tgt_next     = tgt_in;
                    w_next       = w_in;
                    layer_next   = '0;
                    res_num_next = '0;
                    res_next     = '0;
                    if (s_tuser[0] == REQ_READ)
                    begin
                        if (32'(ridx_in) < 32'(total_reg) && 32'(ridx_in) < 32'(MAX_LINKS))
                        begin
                            link_raddr_next = LNK_AW'(ridx_in);
                            state_next      = S_LINK_RD;
                        end
                        else
                        begin
                            res_status_next = ST_UNUSED;
                            state_next      = S_EMIT;
                        end
                    end
                    else if (zero_in)
                    begin
                        res_status_next = ST_ZERO;
                        state_next      = S_EMIT;
                    end
                    else if (32'(tgt_in) >= 32'(TGT_CELLS))
                    begin
                        res_status_next = ST_NOROOM;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_SLOT_RD;
                    end
                end
            end
            S_SLOT_RD:
            begin
                state_next = S_SLOT_CHK;
            end
            S_SLOT_CHK:
            begin
                if (!slot_rd_reg[LNK_AW])
                begin
                    // First empty slot: the source is new for this target.
                    if (32'(total_reg) >= 32'(MAX_LINKS))
                    begin
                        res_status_next = ST_NOROOM;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        res_status_next = ST_NEW;
                        res_num_next    = total_reg[LNK_AW-1:0];
                        res_next.src    = src_reg;
                        res_next.tgt    = tgt_reg;
                        res_next.w      = w_reg;
                        new_next        = 1'b1;
                        state_next      = S_STORE;
                    end
                end
                else
                begin
                    link_raddr_next = slot_rd_reg[LNK_AW-1:0];
                    state_next      = S_LINK_RD;
                end
            end
            S_LINK_RD:
            begin
                state_next = S_LINK_CHK;
            end
            S_LINK_CHK:
            begin
                if (is_read_reg)
                begin
                    res_status_next = ST_READ;
                    res_num_next    = link_raddr_reg;
                    res_next        = link_rd_reg;
                    state_next      = S_EMIT;
                end
                else if (link_rd_reg.src == src_reg)
                begin
                    res_status_next = ST_ACCUM;
                    res_num_next    = link_raddr_reg;
                    res_next        = link_rd_reg;
                    new_next        = 1'b0;
                    acc_idx_next    = '0;
                    state_next      = S_ACC;
                end
                else if (layer_reg + 1'b1 == LAY_W'(MAX_LAYERS))
                begin
                    res_status_next = ST_NOROOM;
                    res_num_next    = '0;
                    res_next        = '0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    layer_next = layer_reg + 1'b1;
                    state_next = S_SLOT_RD;
                end
            end
            S_ACC:
            begin
                res_next.w[acc_idx_reg] = add_sum;
                if (acc_idx_reg == 2'd2 || !three_reg)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    acc_idx_next = acc_idx_reg + 1'b1;
                end
            end
            S_STORE:
            begin
                link_we = 1'b1;
                if (new_reg)
                begin
                    slot_we    = 1'b1;
                    total_next = total_reg + 1'b1;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'({total_reg[CNT_W-1:0] == '0 ? TOT_W'(0)
                                                                     : TOT_W'(total_reg),
                                             res_reg.w[2], res_reg.w[1], res_reg.w[0],
                                             res_reg.tgt, res_reg.src,
                                             NUM_W'(res_num_reg), res_status_reg});
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[slot_addr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[res_num_reg] <= res_reg;
        end
        link_rd_reg <= link_mem[link_raddr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clear_reg     <= 1'b1;
            clr_cnt_reg   <= '0;
            wcnt_reg      <= WCNT_THREE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_reg     <= clear_next;
            clr_cnt_reg   <= clr_cnt_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                wcnt_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        is_read_reg    <= is_read_next;
        three_reg      <= three_next;
        new_reg        <= new_next;
        src_reg        <= src_next;
        tgt_reg        <= tgt_next;
        w_reg          <= w_next;
        layer_reg      <= layer_next;
        link_raddr_reg <= link_raddr_next;
        acc_idx_reg    <= acc_idx_next;
        res_status_reg <= res_status_next;
        res_num_reg    <= res_num_next;
        res_reg        <= res_next;
        out_data_reg   <= out_data_next;
    end

    `SLAS_NEVER(a_total_bound, 32'(total_reg) > 32'(MAX_LINKS), "link count above capacity")
    `SLAS_ASSERT(a_total_step, (state_reg == S_STORE && new_reg) |=> total_reg == $past(total_reg) + 1'b1, "new link did not bump the count")
    `SLAS_NEVER(a_no_beat_clear, clear_reg && accept, "beat taken during slot clearing")
    `SLAS_ASSERT(a_new_nonzero, (out_valid_reg && out_data_reg[2:0] == ST_NEW) |-> out_data_reg[177:165] != '0, "new link reported with zero count")

endmodule

`default_nettype wire
